### sv/windowed_sample_statistics_core_macros.svh
// assertion helpers used by the rtl controller wss_ctrl
`ifndef WINDOWED_SAMPLE_STATISTICS_CORE_MACROS_SVH
`define WINDOWED_SAMPLE_STATISTICS_CORE_MACROS_SVH

// same-cycle implication
`define WSS_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("wss assertion failed");

// next-cycle implication
`define WSS_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("wss assertion failed");

`endif

### sv/wss_pkg.sv
package wss_pkg;

    localparam logic [1:0] FUNC_ADD     = 2'd0;
    localparam logic [1:0] FUNC_REPORT  = 2'd1;
    localparam logic [1:0] FUNC_RESTART = 2'd2;

    localparam logic [1:0] SEL_MEAN = 2'd0;
    localparam logic [1:0] SEL_MS   = 2'd1;
    localparam logic [1:0] SEL_SQ   = 2'd2;

    localparam logic [4:0] WINDOW_LOG2_RESET = 5'd8;
    localparam logic signed [31:0] POS_LIMIT = 32'sh7fffffff;
    localparam logic signed [31:0] NEG_LIMIT = 32'sh80000001;

    typedef struct packed {
        logic       acc_sample;
        logic       clear_win;
        logic       mul_load;
        logic       mul_step;
        logic       div_load;
        logic       div_step;
        logic [1:0] div_sel;
        logic       load_out;
        logic       partial;
    } wss_cmd_t;

    typedef struct packed {
        logic win_full_next;
        logic count_zero;
        logic step_last;
        logic out_free;
    } wss_status_t;

endpackage

### sv/wss_if.sv
interface wss_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic signed [31:0] sample;

    modport source (output valid, func, sample, input ready);
    modport sink (input valid, func, sample, output ready);
endinterface

interface wss_out_if;
    logic               valid;
    logic               ready;
    logic               report_kind;
    logic [16:0]        sample_count;
    logic signed [31:0] min_value;
    logic signed [31:0] max_value;
    logic signed [31:0] mean_value;
    logic [63:0]        mean_square;
    logic [63:0]        variance;
    logic signed [31:0] all_time_min;
    logic signed [31:0] all_time_max;

    modport source (output valid, report_kind, sample_count, min_value, max_value, mean_value,
                    mean_square, variance, all_time_min, all_time_max, input ready);
    modport sink (input valid, report_kind, sample_count, min_value, max_value, mean_value,
                  mean_square, variance, all_time_min, all_time_max, output ready);
endinterface

interface wss_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] window_log2;

    modport source (output valid, window_log2, input ready);
    modport sink (input valid, window_log2, output ready);
endinterface

### sv/windowed_sample_statistics_core.sv
// channel   role    beat
// samples   sink    func, sample
// stats     source  report kind, count, window extremes, mean, mean square, variance, extremes
// cfg       sink    window_log2
//
// a sample that does not close a window leaves the controller idle; samples stream back to back
// closing a window adds the serial squaring of the sum in S_MLOAD and S_MUL before S_EMIT
// a partial report adds three serial divides (mean, mean square, squared mean) on top
// an empty partial report goes straight to the emit state
// samples are taken while a result waits in the output register; a new result waits for it
// rst_n is asynchronous and clears the window, all-time extremes and window_log2 to 8
module windowed_sample_statistics_core #(
    parameter int MAX_WINDOW_LOG2 = 20
) (
    input logic       clk,
    input logic       rst_n,
    wss_in_if.sink    samples,
    wss_out_if.source stats,
    wss_cfg_if.sink   cfg
);
    import wss_pkg::*;

    wss_cmd_t    cmd;
    wss_status_t st;

    wss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_func  (samples.func),
        .in_ready (samples.ready),
        .cmd      (cmd),
        .st       (st)
    );

    wss_dp #(
        .MAX_WINDOW_LOG2 (MAX_WINDOW_LOG2)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (samples.sample),
        .cmd    (cmd),
        .st     (st),
        .cfg    (cfg),
        .stats  (stats)
    );

endmodule

### sv/wss_ctrl.sv
`include "windowed_sample_statistics_core_macros.svh"

module wss_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [1:0]           in_func,
    output logic                 in_ready,
    output wss_pkg::wss_cmd_t    cmd,
    input  wss_pkg::wss_status_t st
);
    import wss_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MLOAD = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_DLOAD = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [1:0] sel_reg, sel_next;
    logic       partial_reg, partial_next;
    logic       accept;
    logic       mul_done, post_mul, in_div, sel_known, report_acc, report_busy;

    always_comb
    begin
        cmd          = '0;
        state_next   = state_reg;
        sel_next     = sel_reg;
        partial_next = partial_reg;
        in_ready     = (state_reg == S_IDLE);
        accept       = in_valid && in_ready;
        cmd.div_sel  = sel_reg;
        cmd.partial  = partial_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_func)
                        FUNC_ADD:
                        begin
                            cmd.acc_sample = 1'b1;
                            if (st.win_full_next)
                            begin
                                partial_next = 1'b0;
                                state_next   = S_MLOAD;
                            end
                        end
                        FUNC_REPORT:
                        begin
                            partial_next = 1'b1;
                            state_next   = st.count_zero ? S_EMIT : S_MLOAD;
                        end
                        FUNC_RESTART:
                        begin
                            cmd.clear_win = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_MLOAD:
            begin
                cmd.mul_load = 1'b1;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (st.step_last)
                begin
                    state_next = partial_reg ? S_DLOAD : S_EMIT;
                    sel_next   = SEL_MEAN;
                end
            end
            S_DLOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.step_last)
                begin
                    if (sel_reg == SEL_SQ)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        sel_next   = sel_reg + 2'd1;
                        state_next = S_DLOAD;
                    end
                end
            end
            S_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.load_out  = 1'b1;
                    cmd.clear_win = !partial_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            sel_reg     <= SEL_MEAN;
            partial_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            sel_reg     <= sel_next;
            partial_reg <= partial_next;
        end
    end

    assign mul_done    = (state_reg == S_MUL) && st.step_last;
    assign post_mul    = (state_reg == S_DLOAD) || (state_reg == S_EMIT);
    assign in_div      = (state_reg == S_DIV) || (state_reg == S_DLOAD);
    assign sel_known   = (sel_reg == SEL_MEAN) || (sel_reg == SEL_MS) || (sel_reg == SEL_SQ);
    assign report_acc  = accept && (in_func == FUNC_REPORT);
    assign report_busy = (state_reg == S_MLOAD) || (state_reg == S_EMIT);

    `WSS_ASSERT_IMP(a_load_free, clk, rst_n, cmd.load_out, st.out_free)
    `WSS_ASSERT_NXT(a_mul_exit, clk, rst_n, mul_done, post_mul)
    `WSS_ASSERT_IMP(a_sel_range, clk, rst_n, in_div, sel_known)
    `WSS_ASSERT_NXT(a_report_busy, clk, rst_n, report_acc, report_busy)

endmodule

### sv/wss_dp.sv
module wss_dp #(
    parameter int MAX_WINDOW_LOG2 = 20
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic signed [31:0]    sample,
    input  wss_pkg::wss_cmd_t     cmd,
    output wss_pkg::wss_status_t  st,
    wss_cfg_if.sink               cfg,
    wss_out_if.source             stats
);
    import wss_pkg::*;

    localparam int CW  = MAX_WINDOW_LOG2 + 1;
    localparam int SW  = 32 + CW;
    localparam int MW  = SW - 1;
    localparam int PW  = 2 * MW;
    localparam int DW  = 2 * CW;
    localparam int SCW = $clog2(PW + 1);
    localparam int LW  = $clog2(MAX_WINDOW_LOG2 + 1);

    logic [4:0]           wl_reg;
    logic [CW-1:0]        count_reg;
    logic signed [SW-1:0] sum_reg;
    logic [63:0]          sq_reg;
    logic signed [31:0]   wmin_reg, wmax_reg, lmin_reg, lmax_reg;
    logic [PW-1:0]        acc_reg, mc_reg, dvd_reg;
    logic [MW-1:0]        mp_reg;
    logic [DW-1:0]        dvs_reg;
    logic [DW:0]          rem_reg;
    logic [63:0]          quo_reg;
    logic [SCW-1:0]       step_reg;
    logic [31:0]          q_mean_reg;
    logic [63:0]          q_ms_reg, q_sq_reg;
    logic                 out_valid_reg;
    logic                 kind_reg;
    logic [16:0]          cnt_out_reg;
    logic signed [31:0]   min_out_reg, max_out_reg, mean_out_reg, amin_out_reg, amax_out_reg;
    logic [63:0]          ms_out_reg, var_out_reg;

    logic [LW-1:0]        l_eff;
    logic [CW-1:0]        count_inc, win_len;
    logic [31:0]          mag32;
    logic [63:0]          sq64;
    logic [MW-1:0]        mag;
    logic [DW-1:0]        cnt_sq;
    logic [DW:0]          r_sh, r_new;
    logic                 ge;
    logic [63:0]          q_new;
    logic [31:0]          mean_full;
    logic [63:0]          ms_full, sq_full;

    assign l_eff     = (wl_reg > 5'(MAX_WINDOW_LOG2)) ? LW'(MAX_WINDOW_LOG2) : LW'(wl_reg);
    assign count_inc = count_reg + CW'(1);
    assign win_len   = CW'(1) << l_eff;
    assign mag32     = sample[31] ? (~sample + 32'd1) : sample;
    assign sq64      = mag32 * mag32;
    assign mag       = sum_reg[SW-1] ? MW'(-sum_reg) : MW'(sum_reg);
    assign cnt_sq    = count_reg * count_reg;
    assign r_sh      = {rem_reg[DW-1:0], dvd_reg[PW-1]};
    assign ge        = r_sh >= {1'b0, dvs_reg};
    assign r_new     = ge ? (r_sh - {1'b0, dvs_reg}) : r_sh;
    assign q_new     = {quo_reg[62:0], ge};
    assign mean_full = 32'(sum_reg >>> l_eff);
    assign ms_full   = sq_reg >> l_eff;
    assign sq_full   = 64'(acc_reg >> {l_eff, 1'b0});

    assign st.win_full_next = count_inc >= win_len;
    assign st.count_zero    = (count_reg == '0);
    assign st.step_last     = (step_reg == SCW'(1));
    assign st.out_free      = !out_valid_reg || stats.ready;

    assign cfg.ready = 1'b1;

    // window and lifetime state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg    <= WINDOW_LOG2_RESET;
            count_reg <= '0;
            sum_reg   <= '0;
            sq_reg    <= '0;
            wmin_reg  <= POS_LIMIT;
            wmax_reg  <= NEG_LIMIT;
            lmin_reg  <= POS_LIMIT;
            lmax_reg  <= NEG_LIMIT;
        end
        else
        begin
            if (cfg.valid)
            begin
                wl_reg <= cfg.window_log2;
            end
            if (cmd.clear_win)
            begin
                count_reg <= '0;
                sum_reg   <= '0;
                sq_reg    <= '0;
                wmin_reg  <= POS_LIMIT;
                wmax_reg  <= NEG_LIMIT;
            end
            else if (cmd.acc_sample)
            begin
                count_reg <= count_inc;
                sum_reg   <= sum_reg + SW'(sample);
                sq_reg    <= sq_reg + sq64;
                if (sample < wmin_reg)
                begin
                    wmin_reg <= sample;
                    if (sample < lmin_reg)
                    begin
                        lmin_reg <= sample;
                    end
                end
                if (sample > wmax_reg)
                begin
                    wmax_reg <= sample;
                    if (sample > lmax_reg)
                    begin
                        lmax_reg <= sample;
                    end
                end
            end
        end
    end

    // step counter shared by multiplier and divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (cmd.mul_load)
        begin
            step_reg <= SCW'(MW);
        end
        else if (cmd.div_load)
        begin
            step_reg <= SCW'(PW);
        end
        else if (cmd.mul_step || cmd.div_step)
        begin
            step_reg <= step_reg - SCW'(1);
        end
    end

    // shift-add multiplier and restoring divider
    always_ff @(posedge clk)
    begin
        if (cmd.mul_load)
        begin
            acc_reg <= '0;
            mc_reg  <= PW'(mag);
            mp_reg  <= mag;
        end
        else if (cmd.mul_step)
        begin
            if (mp_reg[0])
            begin
                acc_reg <= acc_reg + mc_reg;
            end
            mc_reg <= mc_reg << 1;
            mp_reg <= mp_reg >> 1;
        end
        if (cmd.div_load)
        begin
            rem_reg <= '0;
            quo_reg <= '0;
            case (cmd.div_sel)
                SEL_MEAN:
                begin
                    dvd_reg <= PW'(mag);
                    dvs_reg <= DW'(count_reg);
                end
                SEL_MS:
                begin
                    dvd_reg <= PW'(sq_reg);
                    dvs_reg <= DW'(count_reg);
                end
                default:
                begin
                    dvd_reg <= acc_reg;
                    dvs_reg <= cnt_sq;
                end
            endcase
        end
        else if (cmd.div_step)
        begin
            rem_reg <= r_new;
            quo_reg <= q_new;
            dvd_reg <= dvd_reg << 1;
            if (st.step_last)
            begin
                case (cmd.div_sel)
                    SEL_MEAN: q_mean_reg <= sum_reg[SW-1] ? 32'(-q_new) : 32'(q_new);
                    SEL_MS:   q_ms_reg   <= q_new;
                    default:  q_sq_reg   <= q_new;
                endcase
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (stats.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            kind_reg     <= cmd.partial;
            cnt_out_reg  <= 17'(count_reg);
            min_out_reg  <= wmin_reg;
            max_out_reg  <= wmax_reg;
            amin_out_reg <= lmin_reg;
            amax_out_reg <= lmax_reg;
            if (!cmd.partial)
            begin
                mean_out_reg <= mean_full;
                ms_out_reg   <= ms_full;
                var_out_reg  <= ms_full - sq_full;
            end
            else if (st.count_zero)
            begin
                mean_out_reg <= '0;
                ms_out_reg   <= '0;
                var_out_reg  <= '0;
            end
            else
            begin
                mean_out_reg <= q_mean_reg;
                ms_out_reg   <= q_ms_reg;
                var_out_reg  <= q_ms_reg - q_sq_reg;
            end
        end
    end

    assign stats.valid        = out_valid_reg;
    assign stats.report_kind  = kind_reg;
    assign stats.sample_count = cnt_out_reg;
    assign stats.min_value    = min_out_reg;
    assign stats.max_value    = max_out_reg;
    assign stats.mean_value   = mean_out_reg;
    assign stats.mean_square  = ms_out_reg;
    assign stats.variance     = var_out_reg;
    assign stats.all_time_min = amin_out_reg;
    assign stats.all_time_max = amax_out_reg;

endmodule

### bench/windowed_sample_statistics_core_tb.sv
module windowed_sample_statistics_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wss_pkg::*;

    localparam int MAX_WL = 16;
    localparam int IDLE_WAIT = 400;
    localparam int STALL_LIMIT = 5000;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct {
        logic               kind;
        logic [16:0]        cnt;
        logic signed [31:0] mn;
        logic signed [31:0] mx;
        logic signed [31:0] mean;
        logic [63:0]        msq;
        logic [63:0]        vr;
        logic signed [31:0] amn;
        logic signed [31:0] amx;
    } stat_t;

    typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_e;

    typedef struct {
        row_kind_e          kind;
        logic [1:0]         f;
        logic signed [31:0] s;
        logic [4:0]         wl;
        bit                 typed;
        stat_t              e;
    } row_t;

    logic clk;
    logic rst_n;

    wss_in_if  samples_if ();
    wss_out_if stats_if ();
    wss_cfg_if cfg_if ();

    windowed_sample_statistics_core #(
        .MAX_WINDOW_LOG2(MAX_WL)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .samples(samples_if),
        .stats  (stats_if),
        .cfg    (cfg_if)
    );

    // window statistics predictor state
    logic [4:0]         win_log2;
    int unsigned        win_count;
    longint             win_sum;
    logic [63:0]        win_sqsum;
    logic signed [31:0] win_min;
    logic signed [31:0] win_max;
    logic signed [31:0] life_min;
    logic signed [31:0] life_max;

    stat_t stats_expected[$];
    int    error_count;
    int    idle_cycles;
    bit    hold_req;
    bit    beat_typed;
    stat_t beat_typed_stats;
    row_t  rows[$];

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic void clear_window();
        win_count = 0;
        win_sum   = 0;
        win_sqsum = '0;
        win_min   = POS_LIMIT;
        win_max   = NEG_LIMIT;
    endfunction

    function automatic void fill_stats(output stat_t r, input logic kind,
                                       input logic [63:0] mean, input logic [63:0] msq,
                                       input logic [63:0] sqm);
        r.kind = kind;
        r.cnt  = win_count[16:0];
        r.mn   = win_min;
        r.mx   = win_max;
        r.mean = mean[31:0];
        r.msq  = msq;
        r.vr   = msq - sqm;
        r.amn  = life_min;
        r.amx  = life_max;
    endfunction

    function automatic bit window_stats(input logic [1:0] f, input logic signed [31:0] s,
                                        output stat_t r);
        int unsigned  lw;
        logic [63:0]  mag;
        logic [63:0]  mean;
        logic [63:0]  msq;
        logic [127:0] prod;
        longint       v;
        lw = (win_log2 > MAX_WL) ? MAX_WL : win_log2;
        case (f)
            FUNC_ADD:
            begin
                v = s;
                mag = (v < 0) ? 64'(-v) : 64'(v);
                win_count++;
                win_sum += v;
                win_sqsum += mag * mag;
                if (s < win_min)
                begin
                    win_min = s;
                    if (s < life_min)
                        life_min = s;
                end
                if (s > win_max)
                begin
                    win_max = s;
                    if (s > life_max)
                        life_max = s;
                end
                if (win_count < (32'd1 << lw))
                    return 1'b0;
                mean = 64'(win_sum >>> lw);
                msq = win_sqsum >> lw;
                mag = (win_sum < 0) ? 64'(-win_sum) : 64'(win_sum);
                prod = {64'd0, mag} * {64'd0, mag};
                fill_stats(r, 1'b0, mean, msq, 64'(prod >> (2 * lw)));
                clear_window();
                return 1'b1;
            end
            FUNC_REPORT:
            begin
                if (win_count == 0)
                begin
                    fill_stats(r, 1'b1, '0, '0, '0);
                    return 1'b1;
                end
                mag = (win_sum < 0) ? 64'(-win_sum) : 64'(win_sum);
                mean = mag / 64'(win_count);
                if (win_sum < 0)
                    mean = -mean;
                msq = win_sqsum / 64'(win_count);
                prod = {64'd0, mag} * {64'd0, mag};
                fill_stats(r, 1'b1, mean, msq,
                           64'(prod / (128'(win_count) * 128'(win_count))));
                return 1'b1;
            end
            FUNC_RESTART:
            begin
                clear_window();
                return 1'b0;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    task automatic compare_stats(input stat_t e);
        if (stats_if.report_kind !== e.kind)
        begin
            $error("report_kind: expected %0d, got %0d", e.kind, stats_if.report_kind);
            error_count++;
        end
        if (stats_if.sample_count !== e.cnt)
        begin
            $error("sample_count: expected %0d, got %0d", e.cnt, stats_if.sample_count);
            error_count++;
        end
        if (stats_if.min_value !== e.mn)
        begin
            $error("min_value: expected %0d, got %0d", e.mn, stats_if.min_value);
            error_count++;
        end
        if (stats_if.max_value !== e.mx)
        begin
            $error("max_value: expected %0d, got %0d", e.mx, stats_if.max_value);
            error_count++;
        end
        if (stats_if.mean_value !== e.mean)
        begin
            $error("mean_value: expected %0d, got %0d", e.mean, stats_if.mean_value);
            error_count++;
        end
        if (stats_if.mean_square !== e.msq)
        begin
            $error("mean_square: expected %h, got %h", e.msq, stats_if.mean_square);
            error_count++;
        end
        if (stats_if.variance !== e.vr)
        begin
            $error("variance: expected %h, got %h", e.vr, stats_if.variance);
            error_count++;
        end
        if (stats_if.all_time_min !== e.amn)
        begin
            $error("all_time_min: expected %0d, got %0d", e.amn, stats_if.all_time_min);
            error_count++;
        end
        if (stats_if.all_time_max !== e.amx)
        begin
            $error("all_time_max: expected %0d, got %0d", e.amx, stats_if.all_time_max);
            error_count++;
        end
    endtask

    // beat monitor and scoreboard
    always @(posedge clk)
    begin
        stat_t r;
        bit    busy;
        busy = 1'b0;
        if (rst_n)
        begin
            if (cfg_if.valid && cfg_if.ready)
            begin
                win_log2 = cfg_if.window_log2;
                busy = 1'b1;
            end
            if (samples_if.valid && samples_if.ready)
            begin
                busy = 1'b1;
                if (window_stats(samples_if.func, samples_if.sample, r))
                    stats_expected.push_back(beat_typed ? beat_typed_stats : r);
            end
            if (stats_if.valid && stats_if.ready)
            begin
                busy = 1'b1;
                if (stats_expected.size() == 0)
                begin
                    $error("stats beat with nothing expected");
                    error_count++;
                end
                else
                    compare_stats(stats_expected.pop_front());
            end
        end
        idle_cycles = busy ? 0 : idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("** windowed_sample_statistics_core: FAILED **");
            $finish;
        end
    end

    // receiver stall pattern with a single long hold-off
    initial
    begin
        int mode;
        int left;
        stats_if.ready = 1'b0;
        mode = 0;
        left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                stats_if.ready = 1'b0;
                repeat (IDLE_WAIT - 1) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 2);
                    left = $urandom_range(8, 80);
                end
                left--;
                case (mode)
                    0: stats_if.ready = 1'b1;
                    1: stats_if.ready = $urandom_range(0, 1);
                    default: stats_if.ready = ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    task automatic drive_beat(input logic [1:0] f, input logic signed [31:0] s, input int gap,
                              input bit typed, input stat_t e);
        @(negedge clk);
        if (gap > 0)
        begin
            samples_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        samples_if.valid  = 1'b1;
        samples_if.func   = f;
        samples_if.sample = s;
        beat_typed        = typed;
        beat_typed_stats  = e;
        do
            @(posedge clk);
        while (!samples_if.ready);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        samples_if.valid = 1'b0;
        wait (stats_expected.size() == 0);
        repeat (IDLE_WAIT) @(posedge clk);
    endtask

    task automatic write_window_log2(input logic [4:0] wl);
        wait_drained();
        @(negedge clk);
        cfg_if.valid       = 1'b1;
        cfg_if.window_log2 = wl;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    function automatic logic signed [31:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'sh80000001;
            3, 4: return $signed($urandom_range(0, 200)) - 32'sd100;
            default: return $signed($urandom);
        endcase
    endfunction

    function automatic void add_row(input row_kind_e k, input logic [1:0] f,
                                    input logic signed [31:0] s, input logic [4:0] wl,
                                    input bit typed, input stat_t e);
        row_t r;
        r.kind  = k;
        r.f     = f;
        r.s     = s;
        r.wl    = wl;
        r.typed = typed;
        r.e     = e;
        rows.push_back(r);
    endfunction

    initial
    begin
        stat_t none;
        stat_t empty_reset;
        stat_t empty_later;
        logic [4:0] wl_pick[10];
        int burst;
        int gap;
        logic [1:0] f;
        int pick;

        rst_n              = 1'b0;
        samples_if.valid   = 1'b0;
        samples_if.func    = FUNC_ADD;
        samples_if.sample  = '0;
        cfg_if.valid       = 1'b0;
        cfg_if.window_log2 = WINDOW_LOG2_RESET;
        hold_req           = 1'b0;
        beat_typed         = 1'b0;
        error_count        = 0;
        idle_cycles        = 0;
        win_log2           = WINDOW_LOG2_RESET;
        clear_window();
        life_min = POS_LIMIT;
        life_max = NEG_LIMIT;

        none        = '{1'b0, '0, '0, '0, '0, '0, '0, '0, '0};
        empty_reset = '{1'b1, '0, POS_LIMIT, NEG_LIMIT, '0, '0, '0, POS_LIMIT, NEG_LIMIT};
        empty_later = '{1'b1, '0, POS_LIMIT, NEG_LIMIT, '0, '0, '0,
                        32'sh80000000, 32'sh7fffffff};

        // directed rows
        add_row(ROW_BEAT, FUNC_REPORT, 0, 0, 1, empty_reset);
        add_row(ROW_BEAT, FUNC_ADD, 32'sh80000000, 0, 0, none);
        add_row(ROW_BEAT, FUNC_REPORT, 0, 0, 0, none);
        add_row(ROW_BEAT, FUNC_ADD, 32'sh7fffffff, 0, 0, none);
        add_row(ROW_BEAT, FUNC_ADD, -1, 0, 0, none);
        add_row(ROW_BEAT, FUNC_ADD, 1, 0, 0, none);
        add_row(ROW_BEAT, FUNC_REPORT, 0, 0, 0, none);
        add_row(ROW_BEAT, FUNC_UNUSED, 32'sh5a5a5a5a, 0, 0, none);
        add_row(ROW_BEAT, FUNC_RESTART, 32'sh7fffffff, 0, 0, none);
        add_row(ROW_BEAT, FUNC_REPORT, 0, 0, 1, empty_later);
        add_row(ROW_CFG, FUNC_ADD, 0, 5'd0, 0, none);
        add_row(ROW_BEAT, FUNC_ADD, 32'sh80000000, 0, 0, none);
        add_row(ROW_BEAT, FUNC_ADD, 32'sh7fffffff, 0, 0, none);
        add_row(ROW_BEAT, FUNC_ADD, -7, 0, 0, none);
        add_row(ROW_CFG, FUNC_ADD, 0, 5'd1, 0, none);
        add_row(ROW_BEAT, FUNC_ADD, 32'sh80000000, 0, 0, none);
        add_row(ROW_BEAT, FUNC_ADD, 32'sh80000000, 0, 0, none);
        add_row(ROW_BEAT, FUNC_ADD, -3, 0, 0, none);
        add_row(ROW_BEAT, FUNC_ADD, 2, 0, 0, none);
        add_row(ROW_CFG, FUNC_ADD, 0, 5'd31, 0, none);
        for (int i = 0; i < 6; i++)
            add_row(ROW_BEAT, FUNC_ADD, (i % 2) ? 32'sh7fffffff : 32'sh80000000, 0, 0, none);
        add_row(ROW_BEAT, FUNC_REPORT, 0, 0, 0, none);
        add_row(ROW_CFG, FUNC_ADD, 0, 5'd2, 0, none);
        add_row(ROW_BEAT, FUNC_ADD, 32'sh7fffffff, 0, 0, none);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_CFG)
                write_window_log2(rows[i].wl);
            else
                drive_beat(rows[i].f, rows[i].s, 0, rows[i].typed, rows[i].e);
        end

        // random phases
        wl_pick = '{5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd0, 5'd5, 5'd16, 5'd6, 5'd20};
        burst = 0;
        foreach (wl_pick[p])
        begin
            write_window_log2(wl_pick[p]);
            if (p == 5)
                hold_req = 1'b1;
            for (int n = 0; n < 130; n++)
            begin
                gap = 0;
                if (burst == 0)
                begin
                    burst = $urandom_range(1, 40);
                    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
                burst--;
                pick = $urandom_range(0, 99);
                if (pick < 85)
                    f = FUNC_ADD;
                else if (pick < 93)
                    f = FUNC_REPORT;
                else if (pick < 97)
                    f = FUNC_RESTART;
                else
                    f = FUNC_UNUSED;
                drive_beat(f, pick_sample(), gap, 0, none);
            end
        end

        wait_drained();
        if (error_count == 0)
            $display("** windowed_sample_statistics_core: PASSED **");
        else
            $display("** windowed_sample_statistics_core: FAILED **");
        $finish;
    end
endmodule

### files.f
+incdir+sv
sv/wss_pkg.sv
sv/wss_if.sv
sv/wss_ctrl.sv
sv/wss_dp.sv
sv/windowed_sample_statistics_core.sv
bench/windowed_sample_statistics_core_tb.sv
